// ----- design/mskt_pkg.sv -----
// ============================================================================
// mskt_pkg: shared types and constants of the Morse symbol keying timer
// Holds the symbol codes, segment kinds, the queue entry type and state types.
// ============================================================================
package mskt_pkg;

    // Morse text bytes that carry meaning.
    localparam logic [7:0] SYM_DOT   = 8'h2E;
    localparam logic [7:0] SYM_DASH  = 8'h2D;
    localparam logic [7:0] SYM_SPACE = 8'h20;
    localparam logic [7:0] SYM_SLASH = 8'h2F;

    // Register indexes of the configuration port.
    localparam logic CFG_WPM  = 1'b0;
    localparam logic CFG_TONE = 1'b1;

    localparam logic [6:0]  WPM_RESET  = 7'd20;
    localparam logic [11:0] TONE_RESET = 12'd700;

    // Base of the dit length in milliseconds; the dit is this over the speed.
    localparam int DIT_BASE_MS = 1200;
    localparam int DIT_W       = 11;
    localparam int DUR_W       = 14;
    localparam int TONE_W      = 12;
    localparam int WPM_W       = 7;

    typedef enum logic [2:0] {
        KIND_DIT  = 3'd0,
        KIND_DAH  = 3'd1,
        KIND_ELEM = 3'd2,
        KIND_CHAR = 3'd3,
        KIND_WORD = 3'd4
    } seg_kind_t;

    // Pending separator decision carried between bytes.
    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_SPACE = 2'd1,
        PH_SLASH = 2'd2
    } space_phase_t;

    // One queue entry: the segments one input byte causes, one or two of them.
    typedef struct packed {
        seg_kind_t kind0;
        seg_kind_t kind1;
        logic      two;
    } seg_job_t;

    typedef enum logic {
        BACK_FIRST  = 1'b0,
        BACK_SECOND = 1'b1
    } back_state_t;

endpackage

// ----- design/mskt_front.sv -----
// ============================================================================
// mskt_front: symbol classifier
// Accepts Morse text beats, tracks pending separators and queues the segments.
// ============================================================================
module mskt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [7:0]          in_symbol,
    input  logic                in_last,
    input  logic                q_full,
    output logic                in_ready,
    output logic                q_push,
    output mskt_pkg::seg_job_t  q_job
);
    import mskt_pkg::*;

    space_phase_t phase_reg, phase_next;
    logic         armed_reg, armed_next;
    logic         accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        logic      handle;
        logic      is_space;
        logic      is_slash;
        logic [1:0] cnt;
        seg_kind_t k0;
        seg_kind_t k1;
        seg_kind_t kx;
        logic      put;

        is_space   = (in_symbol == SYM_SPACE);
        is_slash   = (in_symbol == SYM_SLASH);
        handle     = 1'b1;
        phase_next = PH_NONE;
        armed_next = armed_reg;
        cnt        = 2'd0;
        k0         = KIND_CHAR;
        k1         = KIND_CHAR;

        // First possible segment: the resolution of a pending separator.
        put = 1'b0;
        kx  = KIND_CHAR;
        case (phase_reg)
            PH_SPACE: begin
                if (is_slash && !in_last) begin
                    phase_next = PH_SLASH;
                    handle     = 1'b0;
                end else begin
                    put = 1'b1;
                end
            end
            PH_SLASH: begin
                put = 1'b1;
                if (is_space) begin
                    kx     = KIND_WORD;
                    handle = 1'b0;
                end
            end
            default: ;
        endcase
        if (put) begin
            k0  = kx;
            cnt = 2'd1;
        end

        // Then the byte itself.
        if (handle) begin
            put = 1'b0;
            if (armed_reg) begin
                armed_next = 1'b0;
                if (!is_space && !is_slash) begin
                    if (cnt == 2'd0) k0 = KIND_ELEM;
                    else             k1 = KIND_ELEM;
                    cnt = cnt + 2'd1;
                end
            end
            if (in_symbol == SYM_DOT) begin
                put        = 1'b1;
                kx         = KIND_DIT;
                armed_next = !in_last;
            end else if (in_symbol == SYM_DASH) begin
                put        = 1'b1;
                kx         = KIND_DAH;
                armed_next = !in_last;
            end else if (is_space) begin
                if (in_last) begin
                    put = 1'b1;
                    kx  = KIND_CHAR;
                end else begin
                    phase_next = PH_SPACE;
                end
            end else if (!is_slash) begin
                armed_next = !in_last;
            end
            if (put) begin
                if (cnt == 2'd0) k0 = kx;
                else             k1 = kx;
                cnt = cnt + 2'd1;
            end
        end

        if (in_last) begin
            phase_next = PH_NONE;
            armed_next = 1'b0;
        end

        q_job.kind0 = k0;
        q_job.kind1 = k1;
        q_job.two   = (cnt == 2'd2);
        q_push      = accept && (cnt != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NONE;
            armed_reg <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            armed_reg <= armed_next;
        end
    end

endmodule

// ----- design/mskt_fifo.sv -----
// ============================================================================
// mskt_fifo: two-entry segment queue
// Decouples the classifier from the segment emitter.
// ============================================================================
module mskt_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mskt_pkg::seg_job_t  push_job,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output mskt_pkg::seg_job_t  head_job
);
    import mskt_pkg::*;

    seg_job_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- design/mskt_back.sv -----
// ============================================================================
// mskt_back: segment emitter
// Turns queued entries into timed keying segments in an output register.
// ============================================================================
module mskt_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mskt_pkg::WPM_W-1:0]    wpm,
    input  logic [mskt_pkg::TONE_W-1:0]   tone_hz,
    input  logic                          head_valid,
    input  mskt_pkg::seg_job_t            head_job,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mskt_pkg::seg_kind_t           out_kind,
    output logic                          out_tone_on,
    output logic [mskt_pkg::DUR_W-1:0]    out_duration,
    output logic [mskt_pkg::TONE_W-1:0]   out_frequency,
    output logic                          out_run_end
);
    import mskt_pkg::*;

    localparam int WPM_N = 1 << WPM_W;

    // Dit length per speed setting; a speed of zero counts as one.
    logic [DIT_W-1:0] dit_lut [WPM_N];
    for (genvar g = 0; g < WPM_N; g++) begin : g_dit
        localparam int DIT_VAL = DIT_BASE_MS / ((g == 0) ? 1 : g);
        assign dit_lut[g] = DIT_VAL[DIT_W-1:0];
    end

    back_state_t state_reg, state_next;
    logic        load;
    logic        last_seg;
    seg_kind_t   cur_kind;
    logic [DIT_W-1:0] dit;
    logic [DUR_W-1:0] dit_x1, dit_x3, dit_x7;
    logic [DUR_W-1:0] duration;
    logic        tone;

    logic                out_valid_reg;
    seg_kind_t           kind_reg;
    logic                tone_on_reg;
    logic [DUR_W-1:0]    duration_reg;
    logic [TONE_W-1:0]   frequency_reg;
    logic                run_end_reg;

    assign load = head_valid && (!out_valid_reg || out_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BACK_FIRST:  if (load && head_job.two) state_next = BACK_SECOND;
            BACK_SECOND: if (load) state_next = BACK_FIRST;
            default:     state_next = BACK_FIRST;
        endcase
    end

    always_comb begin
        case (state_reg)
            BACK_SECOND: begin
                cur_kind = head_job.kind1;
                last_seg = 1'b1;
            end
            default: begin
                cur_kind = head_job.kind0;
                last_seg = !head_job.two;
            end
        endcase
        pop = load && last_seg;
    end

    assign dit    = dit_lut[wpm];
    assign dit_x1 = DUR_W'(dit);
    assign dit_x3 = DUR_W'({dit, 1'b0}) + dit_x1;
    assign dit_x7 = DUR_W'({dit, 3'b000}) - dit_x1;

    always_comb begin
        case (cur_kind)
            KIND_DAH, KIND_CHAR: duration = dit_x3;
            KIND_WORD:           duration = dit_x7;
            default:             duration = dit_x1;
        endcase
        tone = (cur_kind == KIND_DIT) || (cur_kind == KIND_DAH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BACK_FIRST;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load)           out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg      <= cur_kind;
            tone_on_reg   <= tone;
            duration_reg  <= duration;
            frequency_reg <= tone ? tone_hz : '0;
            run_end_reg   <= last_seg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_kind      = kind_reg;
    assign out_tone_on   = tone_on_reg;
    assign out_duration  = duration_reg;
    assign out_frequency = frequency_reg;
    assign out_run_end   = run_end_reg;

endmodule

// ----- design/morse_symbol_keying_timer.sv -----
// ============================================================================
// morse_symbol_keying_timer: Morse text to keying segment converter
// Turns '.', '-', space and '/' bytes into timed tone and gap segments.
// ============================================================================
// Path: an accepted byte is written into the queue, and its first segment is
// then loaded from the queue head into the output register, raising m_tvalid.
// Throughput: one input byte per cycle while the two-entry queue has room;
// the emitter puts out one segment per cycle while m_tready takes them, so a
// byte with two segments keeps its queue entry until the second is loaded.
// Reset: synchronous, active low; clears the separator state, the queue and
// the output valid, and sets the speed to 20 wpm and the tone to 700 Hz.
module morse_symbol_keying_timer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port: index 0 words per minute, index 1 tone in Hz.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_wdata,
    // Input stream of Morse text bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,   // final byte of the string
    // Output stream of keying segments.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [13:0] duration_ms, [25:14] tone_frequency
    output logic [3:0]  m_tuser,   // [2:0] segment_kind, [3] tone_on
    output logic        m_tlast    // run_end: last segment caused by the byte
);
    import mskt_pkg::*;

    // Configuration registers. Writes must arrive only while the block is idle;
    // the user must see to it, not the block. The emitter reads them directly.
    logic [WPM_W-1:0]  wpm_reg;
    logic [TONE_W-1:0] tone_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpm_reg  <= WPM_RESET;
            tone_reg <= TONE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WPM:  wpm_reg  <= cfg_wdata[WPM_W-1:0];
                CFG_TONE: tone_reg <= cfg_wdata[TONE_W-1:0];
                default:  ;
            endcase
        end
    end

    // Front: classifies each byte and resolves pending separators. Every
    // byte that causes segments leaves one queue entry with one or two kinds.
    logic      q_full;
    logic      q_push;
    seg_job_t  q_job;

    mskt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_symbol (s_tdata),
        .in_last   (s_tlast),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // Queue between the two halves, so that a stalled master side does not
    // stop the classifier from taking the next byte right away.
    logic      head_valid;
    seg_job_t  head_job;
    logic      pop;

    mskt_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back: times each segment from the dit table and drives the output
    // register; the entry is popped when its last segment is loaded.
    seg_kind_t          out_kind;
    logic               out_tone_on;
    logic [DUR_W-1:0]   out_duration;
    logic [TONE_W-1:0]  out_frequency;

    mskt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wpm           (wpm_reg),
        .tone_hz       (tone_reg),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_kind      (out_kind),
        .out_tone_on   (out_tone_on),
        .out_duration  (out_duration),
        .out_frequency (out_frequency),
        .out_run_end   (m_tlast)
    );

    assign m_tdata = {6'd0, out_frequency, out_duration};
    assign m_tuser = {out_tone_on, out_kind};

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the Morse symbol keying timer
// Streams directed and random Morse text bytes into the block, predicts the
// keying segments each byte causes, and checks every output beat in order
// under random idling on both sides and one long output stall.
// ============================================================================
module tb_top;
    import mskt_pkg::*;

    // Cycles without any accepted beat or register write before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    // Cycles the output side holds off once, so that the block fills up.
    localparam int LONG_HOLD      = 400;
    // Cycles to let pass after the last expected segment before an idle point.
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 320;

    // One Morse text byte as offered on the input stream.
    typedef struct {
        logic [7:0] symbol;
        logic       last;
    } morse_byte_t;

    // One keying segment as it should appear on the output stream.
    typedef struct {
        seg_kind_t   kind;
        logic        tone_on;
        logic [13:0] duration;
        logic [11:0] freq;
        logic        run_end;
    } keying_seg_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [11:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] symbol
    logic        s_tlast;   // final byte of the string
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [13:0] duration_ms, [25:14] tone_frequency
    logic [3:0]  m_tuser;   // [2:0] segment_kind, [3] tone_on
    logic        m_tlast;   // run_end

    morse_byte_t   byte_q[$];      // bytes waiting to be offered
    keying_seg_t   segment_q[$];   // segments predicted but not yet seen

    // Predictor copy of the configuration and of the separator state.
    logic [6:0]   wpm_setting  = WPM_RESET;
    logic [11:0]  tone_setting = TONE_RESET;
    space_phase_t sep_phase    = PH_NONE;
    logic         gap_armed    = 1'b0;

    int errors      = 0;
    int bytes_sent  = 0;   // bytes handed to the driver
    int bytes_taken = 0;   // bytes accepted by the block
    int idle_cycles = 0;

    // Handshake flags set at the rising edge and read at the next falling edge.
    bit in_beat  = 0;
    bit out_beat = 0;

    morse_symbol_keying_timer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 4 ns clock.
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Builds one segment from its kind and its length in dits, using the
    // speed and tone that are in force right now. A speed of zero counts as 1.
    function automatic keying_seg_t make_segment(seg_kind_t kind, int unsigned dits);
        keying_seg_t  seg;
        int unsigned  speed;
        int unsigned  dit;
        speed          = (wpm_setting == 7'd0) ? 1 : int'(wpm_setting);
        dit            = DIT_BASE_MS / speed;
        seg.kind       = kind;
        seg.tone_on    = (kind == KIND_DIT) || (kind == KIND_DAH);
        seg.duration   = 14'(dit * dits);
        seg.freq       = seg.tone_on ? tone_setting : 12'd0;
        seg.run_end    = 1'b0;
        return seg;
    endfunction

    // Works out the segments that one accepted byte causes and queues them.
    // The separator decision that needs the next byte lives in sep_phase.
    task automatic predict_segments(input logic [7:0] sym, input logic last);
        keying_seg_t segs[2];
        int          n;
        bit          handle;
        n      = 0;
        handle = 1;
        if (sep_phase == PH_SPACE) begin
            // A pending space followed by a slash may still become a word gap.
            if (sym == SYM_SLASH && !last) begin
                sep_phase = PH_SLASH;
                return;
            end
            segs[n] = make_segment(KIND_CHAR, 3);
            n       = n + 1;
            sep_phase = PH_NONE;
        end else if (sep_phase == PH_SLASH) begin
            if (sym == SYM_SPACE) begin
                segs[n] = make_segment(KIND_WORD, 7);
                n       = n + 1;
                handle  = 0;
            end else begin
                // The slash turns out to be stray: a plain character gap.
                segs[n] = make_segment(KIND_CHAR, 3);
                n       = n + 1;
            end
            sep_phase = PH_NONE;
        end
        if (handle) begin
            if (gap_armed) begin
                gap_armed = 1'b0;
                if (sym != SYM_SPACE && sym != SYM_SLASH) begin
                    segs[n] = make_segment(KIND_ELEM, 1);
                    n       = n + 1;
                end
            end
            if (sym == SYM_DOT) begin
                segs[n]   = make_segment(KIND_DIT, 1);
                n         = n + 1;
                gap_armed = !last;
            end else if (sym == SYM_DASH) begin
                segs[n]   = make_segment(KIND_DAH, 3);
                n         = n + 1;
                gap_armed = !last;
            end else if (sym == SYM_SPACE) begin
                if (last) begin
                    segs[n] = make_segment(KIND_CHAR, 3);
                    n       = n + 1;
                end else begin
                    sep_phase = PH_SPACE;
                end
            end else if (sym != SYM_SLASH) begin
                // Any other byte sounds nothing but still arms the element gap.
                gap_armed = !last;
            end
        end
        if (last) begin
            sep_phase = PH_NONE;
            gap_armed = 1'b0;
        end
        if (n > 0)
            segs[n - 1].run_end = 1'b1;
        for (int i = 0; i < n; i++)
            segment_q.push_back(segs[i]);
    endtask

    task automatic check_field(input string name, input int unsigned expected,
                               input int unsigned actual);
        if (expected != actual) begin
            $error("segment field %s: expected %0d, got %0d", name, expected, actual);
            errors++;
        end
    endtask

    // Rising edge: note both handshakes, predict on every accepted input beat
    // and check every accepted output beat against the oldest prediction.
    always @(posedge aclk) begin
        keying_seg_t want;
        in_beat  = aresetn && s_tvalid && s_tready;
        out_beat = aresetn && m_tvalid && m_tready;
        if (in_beat) begin
            predict_segments(s_tdata, s_tlast);
            bytes_taken++;
        end
        if (out_beat) begin
            if (segment_q.size() == 0) begin
                $error("segment beat with nothing expected: kind %0d, duration %0d",
                       m_tuser[2:0], m_tdata[13:0]);
                errors++;
            end else begin
                want = segment_q.pop_front();
                check_field("segment_kind", want.kind, m_tuser[2:0]);
                check_field("tone_on", want.tone_on, m_tuser[3]);
                check_field("duration_ms", want.duration, m_tdata[13:0]);
                check_field("tone_frequency", want.freq, m_tdata[25:14]);
                check_field("tdata_pad", 0, m_tdata[31:26]);
                check_field("run_end", want.run_end, m_tlast);
            end
        end
    end

    // Watchdog: counts cycles in which no beat and no register write happens.
    // It looks at the handshake ports itself, so its order against the
    // monitor at the same edge does not matter.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Input driver. Each byte waits a random gap, drawn anew, before it is
    // offered; now and then the driver flips into a calm stretch with no gaps.
    always @(negedge aclk) begin
        static bit          offering = 0;
        static bit          gap_drawn = 0;
        static bit          tx_calm = 0;
        static int          gap_left = 0;
        static morse_byte_t cur = '{8'h00, 1'b0};
        if (in_beat)
            offering = 0;
        if (!offering && byte_q.size() > 0) begin
            if (!gap_drawn) begin
                if ($urandom_range(0, 31) == 0)
                    tx_calm = !tx_calm;
                gap_left  = tx_calm ? 0 : $urandom_range(0, 4);
                gap_drawn = 1;
            end
            if (gap_left == 0) begin
                cur       = byte_q.pop_front();
                offering  = 1;
                gap_drawn = 0;
            end else begin
                gap_left--;
            end
        end
        s_tvalid <= offering;
        s_tdata  <= cur.symbol;
        s_tlast  <= cur.last;
    end

    // Output side. Each segment waits a random delay before it is taken, with
    // calm stretches too. Once, after 700 bytes are taken, the receiver holds
    // off for a long stretch while the driver keeps offering bytes.
    always @(negedge aclk) begin
        static bit rx_calm = 0;
        static bit hold_started = 0;
        static int hold_left = 0;
        static int rx_wait = 0;
        logic      ready;
        if (out_beat) begin
            if ($urandom_range(0, 31) == 0)
                rx_calm = !rx_calm;
            rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
        end
        if (!hold_started && bytes_taken >= 700) begin
            hold_started = 1;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            ready = 1'b0;
        end else begin
            ready = 1'b1;
        end
        m_tready <= ready;
    end

    task automatic push_byte(input logic [7:0] sym, input logic last);
        morse_byte_t item;
        item.symbol = sym;
        item.last   = last;
        byte_q.push_back(item);
        bytes_sent++;
    endtask

    // Waits until every byte is taken and every segment has come out, then
    // lets SETTLE_CYCLES pass so that a byte with no segment is settled too.
    task automatic wait_drained;
        while (bytes_taken != bytes_sent || segment_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes one register while the block is idle and updates the predictor.
    task automatic write_reg(input logic idx, input logic [11:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        if (idx == CFG_WPM)
            wpm_setting = value[6:0];
        else
            tone_setting = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // One Morse character of one to five elements.
    task automatic push_character(input logic last_here);
        int count;
        count = $urandom_range(1, 5);
        for (int i = 0; i < count; i++)
            push_byte($urandom_range(0, 1) ? SYM_DOT : SYM_DASH,
                      last_here && (i == count - 1));
    endtask

    // One random string: mostly well-formed words of characters separated by
    // space and by space-slash-space, with noise bytes and broken separators
    // mixed in. Most strings end with a last mark, a few run on unmarked.
    task automatic push_string;
        int  words;
        int  chars;
        int  pick;
        bit  mark_end;
        words    = $urandom_range(1, 3);
        mark_end = ($urandom_range(0, 4) != 0);
        for (int w = 0; w < words; w++) begin
            chars = $urandom_range(1, 4);
            for (int c = 0; c < chars; c++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
                end else if (pick == 1) begin
                    // Broken word separator: space and slash, then no space.
                    push_byte(SYM_SPACE, 1'b0);
                    push_byte(SYM_SLASH, 1'b0);
                end else if (pick == 2) begin
                    push_byte(SYM_SLASH, 1'b0);
                end
                push_character(1'b0);
                if (c != chars - 1)
                    push_byte(SYM_SPACE, 1'b0);
            end
            if (w != words - 1) begin
                push_byte(SYM_SPACE, 1'b0);
                push_byte(SYM_SLASH, 1'b0);
                push_byte(SYM_SPACE, 1'b0);
            end
        end
        // The closing byte carries the mark: an element, a trailing space,
        // a trailing slash or a noise byte.
        pick = $urandom_range(0, 7);
        if (pick < 4)
            push_character(mark_end);
        else if (pick == 4)
            push_byte(SYM_SPACE, mark_end);
        else if (pick == 5)
            push_byte(SYM_SLASH, mark_end);
        else if (pick == 6)
            push_byte(8'($urandom_range(0, 255)), mark_end);
        else begin
            push_byte(SYM_SPACE, 1'b0);
            push_byte(SYM_SLASH, mark_end);
        end
    endtask

    initial begin
        logic [6:0]  wpm_plan[6]  = '{7'd1, 7'd100, 7'd0, 7'd127, 7'd13, 7'd0};
        logic [11:0] tone_plan[6] = '{12'd100, 12'd4000, 12'd0, 12'd4095, 12'd1234, 12'd0};
        int          goal;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_WPM;
        cfg_wdata = 12'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset speed and tone.
        // Dit, dah and dit with element gaps between, ending on a last mark.
        push_byte(SYM_DOT, 1'b0);
        push_byte(SYM_DASH, 1'b0);
        push_byte(SYM_DOT, 1'b1);
        // A lone space before a dah gives a character gap first.
        push_byte(SYM_DOT, 1'b0);
        push_byte(SYM_SPACE, 1'b0);
        push_byte(SYM_DASH, 1'b0);
        // Space, slash, space gives a word gap.
        push_byte(SYM_SPACE, 1'b0);
        push_byte(SYM_SLASH, 1'b0);
        push_byte(SYM_SPACE, 1'b0);
        push_byte(SYM_DOT, 1'b0);
        // Space and slash followed by a dah: character gap, the slash is dropped.
        push_byte(SYM_SPACE, 1'b0);
        push_byte(SYM_SLASH, 1'b0);
        push_byte(SYM_DASH, 1'b0);
        // Other bytes play nothing but arm the element gap.
        push_byte(8'h00, 1'b0);
        push_byte(SYM_DOT, 1'b0);
        push_byte(8'hFF, 1'b1);
        // A space that ends the string resolves to a character gap.
        push_byte(SYM_SPACE, 1'b1);
        // Space then a slash carrying the last mark.
        push_byte(SYM_SPACE, 1'b0);
        push_byte(SYM_SLASH, 1'b1);
        // Space, slash, then an ordinary letter byte that ends the string.
        push_byte(SYM_SPACE, 1'b0);
        push_byte(SYM_SLASH, 1'b0);
        push_byte(8'h41, 1'b1);
        // A stray slash, then a dah that ends the string.
        push_byte(SYM_SLASH, 1'b0);
        push_byte(SYM_DASH, 1'b1);
        wait_drained();

        // Random part, one phase per setting, extremes and zero speed among them.
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_WPM, {5'd0, wpm_plan[p]});
            write_reg(CFG_TONE, tone_plan[p]);
            if (p == 5) begin
                write_reg(CFG_WPM, {5'd0, 7'($urandom_range(1, 100))});
                write_reg(CFG_TONE, 12'($urandom_range(100, 4000)));
            end
            goal = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < goal)
                push_string();
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && segment_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/mskt_pkg.sv
design/mskt_front.sv
design/mskt_fifo.sv
design/mskt_back.sv
design/morse_symbol_keying_timer.sv
sim/tb_top.sv
